@@ src/plc_pkg.sv @@
// Package for the piecewise-linear current calibration block.
// Holds sizes, fixed calibration points, the queue item type and the segment base function.
// No dependencies.
package plc_pkg;

	localparam int NUM_POINTS  = 8;                      // calibration points scanned (2..8)
	localparam int REG_COUNT   = 8;                      // configuration registers
	localparam int REG_W       = 19;                     // measured value width
	localparam int CUR_W       = 20;                     // current field width, signed
	localparam int IDX_W       = $clog2(NUM_POINTS);     // segment index width
	localparam int REG_IDX_W   = $clog2(REG_COUNT);      // register index width
	localparam int THRESHOLD   = 150000;                 // 1500 A
	localparam int POINT_BASE  = 160000;                 // true current at point 0
	localparam int POINT_STEP  = 20000;                  // true step between points
	localparam int Q_W         = $clog2(POINT_STEP);     // quotient bits, quotient < POINT_STEP
	localparam int NUM_W       = REG_W + Q_W;            // numerator width
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [REG_COUNT-1:0][REG_W-1:0] meas_bank_t;

	// One classified item travelling from the front to the back.
	typedef struct packed {
		logic                    corr;    // interpolate, else pass through
		logic signed [CUR_W-1:0] sample;
		logic [REG_W-1:0]        diff;    // sample minus lower measured point
		logic [REG_W-1:0]        den;     // span between the two measured points
		logic [IDX_W-1:0]        seg;     // index of the lower point
	} plc_entry_t;

	// True current at the lower point of a segment.
	function automatic logic [CUR_W-1:0] seg_base(input logic [IDX_W-1:0] seg);
		logic [CUR_W-1:0] base;
		base = CUR_W'(POINT_BASE) + CUR_W'(POINT_STEP) * CUR_W'(seg);
		return base;
	endfunction

endpackage

@@ src/piecewise_linear_current_calibration_top.sv @@
// Piecewise-linear current calibration, top level.
// Path from input item accepted to result valid: front stage, queue, multiply,
// 15 divider stages each yielding one quotient bit, output.
// Throughput: one item per cycle while the output is not stalled; the divider is fully pipelined.
// Reset (arst_n, async, active low) clears pipeline valids, queue and all eight
// calibration registers to zero, i.e. an empty table: every sample passes through.
module piecewise_linear_current_calibration_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [plc_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [plc_pkg::REG_W-1:0]            cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [plc_pkg::CUR_W-1:0]     sample_current,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [plc_pkg::CUR_W-1:0]     corrected_current,
	output logic                                 was_corrected
);
	import plc_pkg::*;

	// Calibration table: measured reading at each fixed true point.
	meas_bank_t meas_q;

	// Front to queue
	logic       q_full;
	logic       q_push;
	plc_entry_t front_entry;

	// Queue to back
	logic       q_empty;
	logic       q_pop;
	plc_entry_t back_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q <= '0;
		end else if (cfg_wr_en) begin
			meas_q[cfg_index] <= cfg_data;
		end
	end

	// Front: registers the sample together with the one-hot segment it falls in,
	// then forms numerator difference and span for the divider.
	plc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.meas           (meas_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_current (sample_current),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (front_entry)
	);

	// Two-item queue decouples the front from output back-pressure.
	plc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.rd_entry (back_entry)
	);

	// Back: (diff * step) / span, added to the lower point's true current.
	// Pass-through items ride the same pipeline so order is kept.
	plc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_entry           (back_entry),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.corrected_current (corrected_current),
		.was_corrected     (was_corrected)
	);

endmodule

@@ src/plc_front.sv @@
// Front of the calibration block: accepts samples and locates their segment.
// Depends on plc_pkg.
module plc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plc_pkg::meas_bank_t            meas,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [plc_pkg::CUR_W-1:0] sample_current,
	input  logic                           q_full,
	output logic                           q_push,
	output plc_pkg::plc_entry_t            q_entry
);
	import plc_pkg::*;

	logic                    v_s1;
	logic signed [CUR_W-1:0] sample_s1;
	logic [NUM_POINTS-1:0]   sel_s1;
	logic                    corr_s1;

	logic [NUM_POINTS-1:0]   stop;
	logic [NUM_POINTS-1:0]   first;
	logic [NUM_POINTS-1:0]   sel_c;
	logic                    corr_c;
	logic                    accept;

	// Stop at the first zero register or first measured value above the sample.
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int k = 0; k < NUM_POINTS; k++) begin
			stop[k]  = (meas[k] == '0) ||
				(sample_current < $signed({1'b0, meas[k]}));
			first[k] = stop[k] && !seen;
			seen     = seen || stop[k];
		end
		sel_c    = '0;
		for (int k = 1; k < NUM_POINTS; k++)
			sel_c[k] = first[k] && (meas[k] != '0);
		corr_c = (sample_current > $signed(CUR_W'(THRESHOLD))) && (|sel_c);
	end

	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_current;
			sel_s1    <= sel_c;
			corr_s1   <= corr_c;
		end
	end

	// Per-segment difference and span, then one-hot select.
	always_comb begin
		logic signed [CUR_W:0] d;
		q_entry        = '0;
		q_entry.corr   = corr_s1;
		q_entry.sample = sample_s1;
		for (int k = 1; k < NUM_POINTS; k++) begin
			d = {sample_s1[CUR_W-1], sample_s1} - $signed({2'b00, meas[k-1]});
			if (sel_s1[k]) begin
				q_entry.diff = q_entry.diff | d[REG_W-1:0];
				q_entry.den  = q_entry.den | (meas[k] - meas[k-1]);
				q_entry.seg  = q_entry.seg | IDX_W'(k - 1);
			end
		end
	end

endmodule

@@ src/plc_queue.sv @@
// Short flip-flop queue between the front and the back.
// Depends on plc_pkg.
module plc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  plc_pkg::plc_entry_t wr_entry,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output plc_pkg::plc_entry_t rd_entry
);
	import plc_pkg::*;

	plc_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

@@ src/plc_back.sv @@
// Back of the calibration block: multiply, pipelined restoring divide, output register.
// Depends on plc_pkg.
module plc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  plc_pkg::plc_entry_t              q_entry,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [plc_pkg::CUR_W-1:0] corrected_current,
	output logic                             was_corrected
);
	import plc_pkg::*;

	localparam int LAST = Q_W - 1;

	logic adv;

	// Multiply stage
	logic                    v_s1;
	logic                    corr_s1;
	logic signed [CUR_W-1:0] sample_s1;
	logic [IDX_W-1:0]        seg_s1;
	logic [REG_W-1:0]        den_s1;
	logic [NUM_W-1:0]        num_s1;

	// Divider stages, one quotient bit each
	logic                    v_s2      [Q_W];
	logic                    corr_s2   [Q_W];
	logic signed [CUR_W-1:0] sample_s2 [Q_W];
	logic [IDX_W-1:0]        seg_s2    [Q_W];
	logic [REG_W-1:0]        den_s2    [Q_W];
	logic [REG_W-1:0]        rem_s2    [Q_W];
	logic [Q_W-1:0]          low_s2    [Q_W];
	logic [Q_W-1:0]          quo_s2    [Q_W];

	logic                    out_valid_q;
	logic signed [CUR_W-1:0] corrected_q;
	logic                    was_corrected_q;

	// Whole back pipeline moves when the output register is free or being taken.
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			corr_s1   <= q_entry.corr;
			sample_s1 <= q_entry.sample;
			seg_s1    <= q_entry.seg;
			den_s1    <= q_entry.den;
			num_s1    <= NUM_W'(q_entry.diff) * NUM_W'(POINT_STEP);
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic                    v_in;
		logic                    corr_in;
		logic signed [CUR_W-1:0] sample_in;
		logic [IDX_W-1:0]        seg_in;
		logic [REG_W-1:0]        den_in;
		logic [REG_W-1:0]        rem_in;
		logic [Q_W-1:0]          low_in;
		logic [Q_W-1:0]          quo_in;
		logic [REG_W:0]          trial;
		logic [REG_W:0]          sub;
		logic                    ge;

		if (j == 0) begin : g_first
			// Numerator is below den * 2^Q_W, so the top part starts below den.
			assign v_in      = v_s1;
			assign corr_in   = corr_s1;
			assign sample_in = sample_s1;
			assign seg_in    = seg_s1;
			assign den_in    = den_s1;
			assign rem_in    = num_s1[NUM_W-1:Q_W];
			assign low_in    = num_s1[Q_W-1:0];
			assign quo_in    = '0;
		end else begin : g_next
			assign v_in      = v_s2[j-1];
			assign corr_in   = corr_s2[j-1];
			assign sample_in = sample_s2[j-1];
			assign seg_in    = seg_s2[j-1];
			assign den_in    = den_s2[j-1];
			assign rem_in    = rem_s2[j-1];
			assign low_in    = low_s2[j-1];
			assign quo_in    = quo_s2[j-1];
		end

		assign trial = {rem_in, low_in[Q_W-1]};
		assign ge    = (trial >= {1'b0, den_in});
		assign sub   = trial - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[j] <= 1'b0;
			end else if (adv) begin
				v_s2[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				corr_s2[j]   <= corr_in;
				sample_s2[j] <= sample_in;
				seg_s2[j]    <= seg_in;
				den_s2[j]    <= den_in;
				rem_s2[j]    <= ge ? sub[REG_W-1:0] : trial[REG_W-1:0];
				low_s2[j]    <= {low_in[Q_W-2:0], 1'b0};
				quo_s2[j]    <= {quo_in[Q_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2[LAST];
		end
	end

	// Interpolated value tops out well inside the field limit, so no clamp is built.
	always_ff @(posedge clk) begin
		if (adv) begin
			was_corrected_q <= corr_s2[LAST];
			if (corr_s2[LAST])
				corrected_q <= $signed(seg_base(seg_s2[LAST]) + CUR_W'(quo_s2[LAST]));
			else
				corrected_q <= sample_s2[LAST];
		end
	end

	assign out_valid         = out_valid_q;
	assign corrected_current = corrected_q;
	assign was_corrected     = was_corrected_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the piecewise-linear current calibration block: a directed table of samples,
// then randomised phases with fresh calibration tables, idling and back-pressure.
// Depends on plc_pkg and piecewise_linear_current_calibration_top.
module testbench;
	import plc_pkg::*;

	localparam int CLK_HALF        = 2;      // 4 ns period
	localparam int RESET_CYCLES    = 5;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int PRESSURE_PHASE  = 4;      // a phase with no idling, so the hold fills the block
	localparam int LONG_HOLD       = 200;    // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES    = 40;     // watch time after the last reading, to catch stray items
	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_DIRECTED    = 26;
	localparam int SAMPLE_MAX      = (1 << (CUR_W - 1)) - 1;
	localparam int REG_MAX         = (1 << REG_W) - 1;
	localparam int OUT_MAX         = 400000;
	localparam int OUT_MIN         = -400000;

	// Calibration tables used by the directed part
	typedef enum int {SET_RESET, SET_SKEWED, SET_ENDED, SET_EDGES} cal_set_t;
	// Shapes of randomly drawn tables
	typedef enum int {TBL_RISING, TBL_ENDED, TBL_SCRAMBLED, TBL_EXTREME} table_kind_t;

	typedef struct {
		logic signed [CUR_W-1:0] current;
		logic                    corrected;
	} reading_t;

	typedef struct {
		cal_set_t                bank_set;
		logic signed [CUR_W-1:0] sample;
		bit                      typed;       // expectation written in the row itself
		logic signed [CUR_W-1:0] exp_current;
		logic                    exp_corrected;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [REG_IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [CUR_W-1:0] sample_current;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [CUR_W-1:0] corrected_current;
	logic                    was_corrected;

	meas_bank_t cal_bank;                 // shadow of the eight measured-point registers
	reading_t   expected_readings[$];     // readings still owed by the block, oldest first
	stim_row_t  directed_rows [NUM_DIRECTED];
	int         errors         = 0;
	int         cycles         = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         hold_requests  = 0;       // bumped by the stimulus, served by the receiver
	int         holds_done     = 0;

	piecewise_linear_current_calibration_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample_current    (sample_current),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.corrected_current (corrected_current),
		.was_corrected     (was_corrected)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Corrected reading for one sample against a given table. Scan from point 0; a zero
	// register ends the table, the first larger measured value picks the segment, and a sample
	// at or below the threshold or below point 0 passes through untouched.
	function automatic reading_t calibrate(input logic signed [CUR_W-1:0] s,
			input meas_bank_t bank);
		reading_t r;
		longint   sv, m, m0, v;
		bit       done;
		int       k;
		r.current   = s;
		r.corrected = 1'b0;
		sv          = s;
		done        = 1'b0;
		if (sv > THRESHOLD) begin
			for (k = 0; k < NUM_POINTS && k < REG_COUNT && !done; k++) begin
				m = longint'(bank[k]);
				if (m == 0) begin
					done = 1'b1;
				end else if (sv < m) begin
					if (k > 0) begin
						// lower point is at or below the sample, so the span is positive
						m0 = longint'(bank[k-1]);
						v  = POINT_BASE + POINT_STEP * (k - 1)
							+ ((sv - m0) * POINT_STEP) / (m - m0);
						if (v > OUT_MAX)
							v = OUT_MAX;
						if (v < OUT_MIN)
							v = OUT_MIN;
						r.current   = v[CUR_W-1:0];
						r.corrected = 1'b1;
					end
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Mostly rising tables starting near the 1500 A threshold; the other shapes cut the table
	// short, scramble it, or pin its ends just above the threshold and at the register's top.
	function automatic meas_bank_t random_bank(input table_kind_t kind);
		meas_bank_t bank;
		longint     level;
		int         k;
		level = 140000 + longint'($urandom_range(30000, 0));
		for (k = 0; k < REG_COUNT; k++) begin
			if (level > REG_MAX)
				level = REG_MAX;
			bank[k] = level[REG_W-1:0];
			level += longint'($urandom_range(45000, 1));
		end
		case (kind)
			TBL_ENDED: bank[$urandom_range(REG_COUNT - 1, 0)] = '0;
			TBL_SCRAMBLED: begin
				for (k = 0; k < REG_COUNT; k++)
					bank[k] = ($urandom_range(7, 0) == 0) ? '0 : REG_W'($urandom);
			end
			TBL_EXTREME: begin
				bank[0]             = REG_W'(THRESHOLD + 1);
				bank[REG_COUNT - 1] = '1;
			end
			default: ;
		endcase
		return bank;
	endfunction

	// Samples aimed at the table: inside a segment, right on a point, around the
	// threshold, with the rest drawn over the whole field.
	function automatic logic signed [CUR_W-1:0] random_sample(input meas_bank_t bank);
		longint s, lo, hi;
		int     k, pick;
		pick = $urandom_range(99, 0);
		k    = $urandom_range(REG_COUNT - 2, 0);
		lo   = longint'(bank[k]);
		hi   = longint'(bank[k+1]);
		if (pick < 60)
			s = (hi > lo) ? lo + longint'($urandom_range(int'(hi - lo), 0))
				: lo + longint'($urandom_range(1000, 0));
		else if (pick < 72)
			s = lo + longint'($urandom_range(2, 0)) - 1;
		else if (pick < 82)
			s = 100000 + longint'($urandom_range(100000, 0));
		else
			s = longint'($urandom);
		if (pick < 82 && s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		return s[CUR_W-1:0];
	endfunction

	// Write all eight registers, one per cycle. Only called with the block idle.
	task automatic load_bank(input meas_bank_t bank);
		int i;
		for (i = 0; i < REG_COUNT; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data  <= bank[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cal_bank = bank;
	endtask

	// Drop valid and wait until every owed reading has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Offer one item, with random idle cycles in front of it, and hold it until taken.
	// Entered and left in the time step of a rising edge.
	task automatic offer_sample(input logic signed [CUR_W-1:0] s, input reading_t want);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		sample_current <= s;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		expected_readings.push_back(want);
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Result checker: values sampled at the edge are those from before it
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected item, current %0d corrected %0b",
					$time, corrected_current, was_corrected);
				errors++;
			end else begin
				want = expected_readings.pop_front();
				if (corrected_current !== want.current) begin
					$display("%0t: corrected_current expected %0d actual %0d",
						$time, want.current, corrected_current);
					errors++;
				end
				if (was_corrected !== want.corrected) begin
					$display("%0t: was_corrected expected %0b actual %0b",
						$time, want.corrected, was_corrected);
					errors++;
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		stim_row_t               row;
		cal_set_t                loaded;
		int                      pts [REG_COUNT];
		meas_bank_t              bank;
		reading_t                want;
		logic signed [CUR_W-1:0] s;
		int                      i, n, p;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		sample_current = '0;
		cal_bank       = '0;

		// Typed rows: pass-through cases and samples sitting exactly on a point
		directed_rows = '{
			// empty table after reset: everything passes through
			'{SET_RESET,  20'sh80000,   1'b1, 20'sh80000,   1'b0},
			'{SET_RESET,  20'sh7FFFF,   1'b1, 20'sh7FFFF,   1'b0},
			'{SET_RESET,  20'sd0,       1'b1, 20'sd0,       1'b0},
			'{SET_RESET,  20'sd150000,  1'b1, 20'sd150000,  1'b0},
			'{SET_RESET,  20'sd150001,  1'b1, 20'sd150001,  1'b0},
			'{SET_RESET,  -20'sd400000, 1'b1, -20'sd400000, 1'b0},
			'{SET_RESET,  20'sd400000,  1'b1, 20'sd400000,  1'b0},
			'{SET_RESET,  -20'sd1,      1'b1, -20'sd1,      1'b0},
			// full, uneven table
			'{SET_SKEWED, 20'sd150001,  1'b1, 20'sd150001,  1'b0},
			'{SET_SKEWED, 20'sd157999,  1'b1, 20'sd157999,  1'b0},
			'{SET_SKEWED, 20'sd158000,  1'b1, 20'sd160000,  1'b1},
			'{SET_SKEWED, 20'sd177000,  1'b1, 20'sd180000,  1'b1},
			'{SET_SKEWED, 20'sd279000,  1'b1, 20'sd280000,  1'b1},
			'{SET_SKEWED, 20'sd301000,  1'b1, 20'sd301000,  1'b0},
			'{SET_SKEWED, 20'sd200000,  1'b0, 20'sd0,       1'b0},
			'{SET_SKEWED, 20'sd300999,  1'b0, 20'sd0,       1'b0},
			'{SET_SKEWED, 20'sd170000,  1'b0, 20'sd0,       1'b0},
			'{SET_SKEWED, 20'sh7FFFF,   1'b1, 20'sh7FFFF,   1'b0},
			// zero at point 4 ends the table
			'{SET_ENDED,  20'sd229999,  1'b0, 20'sd0,       1'b0},
			'{SET_ENDED,  20'sd230000,  1'b1, 20'sd230000,  1'b0},
			'{SET_ENDED,  20'sd310000,  1'b1, 20'sd310000,  1'b0},
			// points hard against the threshold and the top of the register
			'{SET_EDGES,  20'sd150200,  1'b1, 20'sd160000,  1'b1},
			'{SET_EDGES,  20'sd150201,  1'b1, 20'sd180000,  1'b1},
			'{SET_EDGES,  20'sd400000,  1'b1, 20'sd280000,  1'b1},
			'{SET_EDGES,  20'sd524286,  1'b0, 20'sd0,       1'b0},
			'{SET_EDGES,  20'sh7FFFF,   1'b1, 20'sh7FFFF,   1'b0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		loaded = SET_RESET;
		for (i = 0; i < NUM_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.bank_set != loaded) begin
				wait_idle();
				case (row.bank_set)
					SET_SKEWED: pts = '{158000, 177000, 199500, 221000,
						240000, 262000, 279000, 301000};
					SET_ENDED:  pts = '{155000, 180000, 205000, 230000,
						0, 300000, 320000, 340000};
					default:    pts = '{150200, 150201, 200000, 250000,
						300000, 350000, 400000, REG_MAX};
				endcase
				for (n = 0; n < REG_COUNT; n++)
					bank[n] = REG_W'(pts[n]);
				load_bank(bank);
				loaded = row.bank_set;
			end
			if (row.typed) begin
				want.current   = row.exp_current;
				want.corrected = row.exp_corrected;
			end else
				want = calibrate(row.sample, cal_bank);
			offer_sample(row.sample, want);
		end

		// Random phases: a fresh table and a fresh idling pattern each time
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			load_bank(random_bank(table_kind_t'((p + p / 4) % 4)));
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 66;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 66;
				end
				default: begin
					send_idle_pct  = 38;
					recv_stall_pct = 38;
				end
			endcase
			// receiver holds off while items keep coming, so in_stall must rise
			if (p == PRESSURE_PHASE)
				hold_requests++;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				s = random_sample(cal_bank);
				offer_sample(s, calibrate(s, cal_bank));
			end
		end

		// Let the last readings out, then watch a little longer for strays
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
src/plc_pkg.sv
src/plc_front.sv
src/plc_queue.sv
src/plc_back.sv
src/piecewise_linear_current_calibration_top.sv
verif/testbench.sv
